[rtl/wsp_pkg.sv]
// Shared types, constants and helper functions for the world-to-screen projection block.
`default_nettype none
package wsp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_COEFS     = 12;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 31;

  // Transaction kinds.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_POINT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH     = 3'd4;

  localparam logic signed [15:0] WINDOW_LEFT_RST   = 16'sd0;
  localparam logic signed [15:0] WINDOW_TOP_RST    = 16'sd0;
  localparam logic [14:0]        WINDOW_WIDTH_RST  = 15'd1920;
  localparam logic [14:0]        WINDOW_HEIGHT_RST = 15'd1080;
  localparam logic [30:0]        MIN_DEPTH_RST     = 31'd655;

  typedef struct packed {
    logic               func;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] window_left;
    logic signed [15:0] window_top;
    logic [14:0]        window_width;
    logic [14:0]        window_height;
  } view_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/wsp_clip.sv]
// Coefficient store and the three row dot products that form clip x, y and w.
`default_nettype none
module wsp_clip #(
  parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              take,
  input  wire wsp_pkg::in_item_t item,
  output logic                   valid,
  output logic signed [31:0]     cx,
  output logic signed [31:0]     cy,
  output logic signed [31:0]     cw
);

  logic signed [31:0] mat [0:wsp_pkg::NUM_COEFS-1];
  logic signed [63:0] prod [0:8];
  logic signed [31:0] offs [0:2];
  logic signed [65:0] sum_a [0:2];
  logic signed [65:0] sum_b [0:2];
  logic               v1;
  logic               v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wsp_pkg::NUM_COEFS; i++) begin
        mat[i] <= '0;
      end
    end else if (take && item.func == wsp_pkg::FUNC_LOAD &&
                 item.coef_index < 4'(wsp_pkg::NUM_COEFS)) begin
      mat[item.coef_index] <= item.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= take && item.func == wsp_pkg::FUNC_POINT;
      v2    <= v1;
      valid <= v2;
    end
  end

  // Products use the matrix as it stands when the point transaction is taken.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod[3*r]   <= mat[4*r]   * item.point_x;
        prod[3*r+1] <= mat[4*r+1] * item.point_y;
        prod[3*r+2] <= mat[4*r+2] * item.point_z;
        offs[r]     <= mat[4*r+3];
      end
      for (int r = 0; r < 3; r++) begin
        sum_a[r] <= 66'(prod[3*r] >>> FRAC_BITS) + 66'(prod[3*r+1] >>> FRAC_BITS);
        sum_b[r] <= 66'(prod[3*r+2] >>> FRAC_BITS) + 66'(offs[r]);
      end
      cx <= wsp_pkg::sat32(sum_a[0] + sum_b[0]);
      cy <= wsp_pkg::sat32(sum_a[1] + sum_b[1]);
      cw <= wsp_pkg::sat32(sum_a[2] + sum_b[2]);
    end
  end

endmodule
`default_nettype wire

[rtl/wsp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, giving a saturated ndc value.
`default_nettype none
module wsp_div #(
  parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic          in_vis,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic               out_valid,
  output logic               out_vis,
  output logic signed [31:0] quot
);

  localparam int NW = 32 + FRAC_BITS;

  logic        pv   [0:32];
  logic        pvis [0:32];
  logic        psgn [0:32];
  logic        povf [0:32];
  logic [32:0] prem [0:32];
  logic [31:0] pden [0:32];
  logic [31:0] pnlo [0:32];
  logic [31:0] pq   [0:32];

  logic [31:0]   mag;
  logic [31:0]   den_eff;
  logic [NW-1:0] nfull;

  always_comb begin
    mag     = num[31] ? (~num + 32'd1) : num;
    den_eff = (den == '0) ? 32'd1 : den;
    nfull   = {mag, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else if (en) begin
      pv[0] <= in_valid;
    end
  end

  // A quotient of 2^32 or more saturates, so only 32 quotient bits are formed.
  always_ff @(posedge clk) begin
    if (en) begin
      pvis[0] <= in_vis;
      psgn[0] <= num[31];
      povf[0] <= 32'(nfull[NW-1:32]) >= den_eff;
      prem[0] <= 33'(nfull[NW-1:32]);
      pden[0] <= den_eff;
      pnlo[0] <= nfull[31:0];
      pq[0]   <= '0;
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_stage
    logic [32:0] trial;
    assign trial = {prem[k][31:0], pnlo[k][31]};

    always_ff @(posedge clk) begin
      if (rst) begin
        pv[k+1] <= 1'b0;
      end else if (en) begin
        pv[k+1] <= pv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pvis[k+1] <= pvis[k];
        psgn[k+1] <= psgn[k];
        povf[k+1] <= povf[k];
        pden[k+1] <= pden[k];
        pnlo[k+1] <= {pnlo[k][30:0], 1'b0};
        if (trial >= {1'b0, pden[k]}) begin
          prem[k+1] <= trial - {1'b0, pden[k]};
          pq[k+1]   <= {pq[k][30:0], 1'b1};
        end else begin
          prem[k+1] <= trial;
          pq[k+1]   <= {pq[k][30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pv[32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vis <= pvis[32];
      if (psgn[32]) begin
        if (povf[32] || pq[32] > 32'h8000_0000) begin
          quot <= 32'sh8000_0000;
        end else begin
          quot <= -$signed(pq[32]);
        end
      end else begin
        if (povf[32] || pq[32][31]) begin
          quot <= 32'sh7FFF_FFFF;
        end else begin
          quot <= $signed(pq[32]);
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/wsp_view.sv]
// Viewport mapping of ndc values to window pixel coordinates, ending in the output register.
`default_nettype none
module wsp_view #(
  parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic               in_vis,
  input  wire logic signed [31:0] nx,
  input  wire logic signed [31:0] ny,
  input  wire wsp_pkg::view_cfg_t cfg,
  output logic                    out_valid,
  output wsp_pkg::out_item_t      out_item
);

  logic               v1;
  logic               vis1;
  logic signed [47:0] mx;
  logic signed [47:0] my;

  logic signed [65:0] half_w;
  logic signed [65:0] half_h;
  logic signed [65:0] one;
  logic signed [65:0] left2;
  logic signed [65:0] top2;
  logic signed [65:0] mx_e;
  logic signed [65:0] my_e;
  logic signed [65:0] tx;
  logic signed [65:0] ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_comb begin
    half_w = $signed(66'(cfg.window_width >> 1)) <<< (FRAC_BITS + 1);
    half_h = $signed(66'(cfg.window_height >> 1)) <<< (FRAC_BITS + 1);
    one    = 66'sd1 <<< FRAC_BITS;
    left2  = 66'(cfg.window_left);
    left2  = left2 <<< (FRAC_BITS + 1);
    top2   = 66'(cfg.window_top);
    top2   = top2 <<< (FRAC_BITS + 1);
    mx_e   = 66'(mx);
    my_e   = 66'(my);
    // Both sums are twice the pixel position; halving with floor follows.
    tx     = half_w + mx_e + one + left2;
    ty     = half_h - my_e - one + top2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis1 <= in_vis;
      mx   <= nx * $signed({1'b0, cfg.window_width});
      my   <= ny * $signed({1'b0, cfg.window_height});
      out_item.visible <= vis1;
      if (vis1) begin
        out_item.screen_x <= wsp_pkg::sat32(tx >>> 1);
        out_item.screen_y <= wsp_pkg::sat32(ty >>> 1);
      end else begin
        out_item.screen_x <= '0;
        out_item.screen_y <= '0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/world_to_screen_projection.sv]
// Top level of the world-to-screen projection pipeline.
//
//  Channel | Signals                               | Moves
//  input   | in_valid, in_ready, in_data           | coefficient load or point
//  output  | out_valid, out_ready, out_data        | visibility and pixel position
//  config  | cfg_we, cfg_index, cfg_data           | window and depth registers
//
// One transaction enters per cycle unless the output stalls. A point result passes
// three clip stages, 34 divider stages (input register, one per quotient bit,
// output register) and two viewport stages. Loads write the matrix at once and
// give no result. Reset clears valid bits and the matrix and presets the registers.
// When the output register holds an untaken result, the whole pipeline holds.
`default_nettype none
module world_to_screen_projection #(
  parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire wsp_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output wsp_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_we,
  input  wire logic [wsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [wsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  wsp_pkg::view_cfg_t view_cfg;
  logic [30:0]        min_depth;
  logic               adv;
  logic               take;

  logic               clip_valid;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cw;
  logic               clip_vis;

  logic               dx_valid;
  logic               dx_vis;
  logic signed [31:0] nx;
  logic               dy_valid;
  logic               dy_vis;
  logic signed [31:0] ny;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign take     = in_valid && in_ready;
  assign clip_vis = cw >= $signed({1'b0, min_depth});

  always_ff @(posedge clk) begin
    if (rst) begin
      view_cfg.window_left   <= wsp_pkg::WINDOW_LEFT_RST;
      view_cfg.window_top    <= wsp_pkg::WINDOW_TOP_RST;
      view_cfg.window_width  <= wsp_pkg::WINDOW_WIDTH_RST;
      view_cfg.window_height <= wsp_pkg::WINDOW_HEIGHT_RST;
      min_depth              <= wsp_pkg::MIN_DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wsp_pkg::REG_WINDOW_LEFT:   view_cfg.window_left   <= cfg_data[15:0];
        wsp_pkg::REG_WINDOW_TOP:    view_cfg.window_top    <= cfg_data[15:0];
        wsp_pkg::REG_WINDOW_WIDTH:  view_cfg.window_width  <= cfg_data[14:0];
        wsp_pkg::REG_WINDOW_HEIGHT: view_cfg.window_height <= cfg_data[14:0];
        wsp_pkg::REG_MIN_DEPTH:     min_depth              <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  wsp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .take  (take),
    .item  (in_data),
    .valid (clip_valid),
    .cx    (cx),
    .cy    (cy),
    .cw    (cw)
  );

  wsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (clip_valid),
    .in_vis    (clip_vis),
    .num       (cx),
    .den       (cw),
    .out_valid (dx_valid),
    .out_vis   (dx_vis),
    .quot      (nx)
  );

  wsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (clip_valid),
    .in_vis    (clip_vis),
    .num       (cy),
    .den       (cw),
    .out_valid (dy_valid),
    .out_vis   (dy_vis),
    .quot      (ny)
  );

  wsp_view #(.FRAC_BITS(FRAC_BITS)) u_view (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (dx_valid && dy_valid),
    .in_vis    (dx_vis && dy_vis),
    .nx        (nx),
    .ny        (ny),
    .cfg       (view_cfg),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.visible |-> out_data.screen_x == '0 && out_data.screen_y == '0)
    else $error("hidden point has nonzero position");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is stalled");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    dx_valid == dy_valid)
    else $error("divider lanes out of step");

endmodule
`default_nettype wire

[sim/world_to_screen_projection_tb.sv]
// Testbench for the world-to-screen projection block: directed table plus random traffic.
`timescale 1ns / 100ps
`default_nettype none
module world_to_screen_projection_tb;
  import wsp_pkg::*;

  localparam int LATENCY   = 40;
  localparam int MAX_CYCLE = 1000000;

  typedef struct {
    in_item_t  item;
    bit        has_exp;
    out_item_t exp_res;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the block's matrix and registers.
  logic signed [31:0] coefs [NUM_COEFS];
  logic signed [15:0] win_left, win_top;
  logic [14:0]        win_w, win_h;
  logic [30:0]        depth_min;

  out_item_t   pending_pos [$];
  stim_row_t   table_rows [$];
  int          errors = 0;
  longint      cycle = 0;
  bit          stall_en = 1'b1;

  world_to_screen_projection i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint fdiv(longint v, longint d);
    if (v >= 0) return v / d;
    return -((-v + d - 1) / d);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip_dot(int row, longint x, longint y, longint z);
    longint s;
    s = fdiv(longint'(coefs[row*4]) * x, 65536) + fdiv(longint'(coefs[row*4+1]) * y, 65536)
      + fdiv(longint'(coefs[row*4+2]) * z, 65536) + longint'(coefs[row*4+3]);
    return clamp32(s);
  endfunction

  function automatic out_item_t project_point(in_item_t it);
    out_item_t r;
    longint cx, cy, w, nx, ny, tx, ty, ww, hh;
    cx = clip_dot(0, it.point_x, it.point_y, it.point_z);
    cy = clip_dot(1, it.point_x, it.point_y, it.point_z);
    w  = clip_dot(2, it.point_x, it.point_y, it.point_z);
    r = '0;
    if (w < longint'(depth_min)) return r;
    if (w == 0) w = 1;
    nx = clamp32((cx * 65536) / w);
    ny = clamp32((cy * 65536) / w);
    ww = longint'(win_w);
    hh = longint'(win_h);
    tx = 2 * (ww / 2) * 65536 + nx * ww + 65536 + 2 * longint'(win_left) * 65536;
    ty = 2 * (hh / 2) * 65536 - ny * hh - 65536 + 2 * longint'(win_top) * 65536;
    r.visible  = 1'b1;
    r.screen_x = 32'(clamp32(fdiv(tx, 2)));
    r.screen_y = 32'(clamp32(fdiv(ty, 2)));
    return r;
  endfunction

  // Updates the shadow matrix for a load; for a point, checks any table entry and queues its result.
  task automatic track_item(in_item_t it, bit has_exp, out_item_t exp_res);
    out_item_t p;
    if (it.func == FUNC_LOAD) begin
      if (it.coef_index < NUM_COEFS) coefs[it.coef_index] = it.coef_value;
    end else begin
      p = project_point(it);
      if (has_exp && p != exp_res) begin
        $display("%0t table entry disagrees with predictor: exp %h got %h", $time, exp_res, p);
        errors++;
      end
      pending_pos.push_back(p);
    end
  endtask

  // Valid stays high after the transaction so that a following one can go back to back;
  // whoever idles the sender drops it.
  task automatic send_item(in_item_t it, bit has_exp, out_item_t exp_res);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_item(it, has_exp, exp_res);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WINDOW_LEFT:   win_left = val[15:0];
      REG_WINDOW_TOP:    win_top = val[15:0];
      REG_WINDOW_WIDTH:  win_w = val[14:0];
      REG_WINDOW_HEIGHT: win_h = val[14:0];
      REG_MIN_DEPTH:     depth_min = val[30:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pos.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_pos.size() == 0) begin
        $display("%0t unexpected result: got %h", $time, out_data);
        errors++;
      end else begin
        e = pending_pos.pop_front();
        if (out_data.visible !== e.visible)
          $display("%0t visible mismatch: exp %b got %b", $time, e.visible, out_data.visible);
        if (out_data.screen_x !== e.screen_x)
          $display("%0t screen_x mismatch: exp %h got %h", $time, e.screen_x, out_data.screen_x);
        if (out_data.screen_y !== e.screen_y)
          $display("%0t screen_y mismatch: exp %h got %h", $time, e.screen_y, out_data.screen_y);
        if (out_data !== e) errors++;
      end
    end
  end

  // Receiver stalls, while stall_en is set, in a pattern of its own: long open runs, then bursts of stalls.
  always @(negedge clk) begin
    if (!stall_en) out_ready <= 1'b1;
    else if (cycle % 256 < 64) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  function automatic in_item_t load_item(int idx, logic [31:0] val);
    in_item_t it;
    it = '0;
    it.func = FUNC_LOAD;
    it.coef_index = 4'(idx);
    it.coef_value = val;
    return it;
  endfunction

  function automatic in_item_t point_item(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it = '0;
    it.func = FUNC_POINT;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    return it;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      2: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      default: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic void add_row(in_item_t it, bit has_exp, out_item_t e);
    stim_row_t r;
    r.item = it;
    r.has_exp = has_exp;
    r.exp_res = e;
    table_rows.push_back(r);
  endfunction

  task automatic random_phase(int n);
    int sent, burst;
    in_item_t it;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        if ($urandom_range(0, 9) < 2) begin
          it = load_item($urandom_range(0, 15), rand_coord());
          // Keep the depth row mostly positive so most points are visible.
          if (it.coef_index == 11 && $urandom_range(0, 3) != 0)
            it.coef_value = $urandom_range(32'h0001_0000, 32'h0040_0000);
        end else begin
          it = point_item(rand_coord(), rand_coord(), rand_coord());
        end
        send_item(it, 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  endtask

  initial begin
    out_item_t z, e;
    int k;
    for (k = 0; k < NUM_COEFS; k++) coefs[k] = '0;
    win_left = WINDOW_LEFT_RST;
    win_top = WINDOW_TOP_RST;
    win_w = WINDOW_WIDTH_RST;
    win_h = WINDOW_HEIGHT_RST;
    depth_min = MIN_DEPTH_RST;
    z = '0;

    // Directed table. All-zero matrix after reset gives w = 0 below min_depth: not visible.
    add_row(point_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000), 1'b1, z);
    add_row(load_item(15, 32'h0001_0000), 1'b0, z);    // slot out of range, ignored
    add_row(point_item('0, '0, '0), 1'b1, z);
    add_row(load_item(11, 32'h0001_0000), 1'b0, z);    // w = 1.0
    // Origin maps to viewport center: 960.5, 539.5.
    e = '0; e.visible = 1'b1; e.screen_x = 32'h03C0_8000; e.screen_y = 32'h021B_8000;
    add_row(point_item('0, '0, '0), 1'b1, e);
    add_row(load_item(0, 32'h0001_0000), 1'b0, z);
    add_row(load_item(5, 32'h0001_0000), 1'b0, z);
    add_row(load_item(10, 32'h0001_0000), 1'b0, z);
    add_row(load_item(3, 32'h7FFF_FFFF), 1'b0, z);
    add_row(load_item(7, 32'h8000_0000), 1'b0, z);
    add_row(point_item(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000), 1'b0, z);
    add_row(point_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, z);
    add_row(point_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0, z);
    add_row(load_item(1, 32'hFFFF_FFFF), 1'b0, z);
    add_row(load_item(2, 32'h8000_0000), 1'b0, z);
    add_row(load_item(4, 32'h7FFF_FFFF), 1'b0, z);
    add_row(load_item(6, 32'h0000_0001), 1'b0, z);
    add_row(load_item(8, 32'h0000_0100), 1'b0, z);
    add_row(load_item(9, 32'hFFFF_FF00), 1'b0, z);
    add_row(point_item(32'h0123_4567, 32'hFEDC_BA98, 32'h0000_FFFF), 1'b0, z);
    add_row(point_item(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_AAAA), 1'b0, z);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) send_item(table_rows[i].item, table_rows[i].has_exp,
                                      table_rows[i].exp_res);
    drain();

    // Extreme settings, including zero depth with zero w and a window of zero height.
    write_reg(REG_MIN_DEPTH, '0);
    write_reg(REG_WINDOW_WIDTH, 31'(16384));
    write_reg(REG_WINDOW_HEIGHT, 31'(0));
    write_reg(REG_WINDOW_LEFT, 31'h0000_7FFF);
    write_reg(REG_WINDOW_TOP, 31'h0000_8000);
    for (k = 0; k < 12; k++) send_item(load_item(k, '0), 1'b0, z);
    send_item(point_item(32'h0100_0000, '0, '0), 1'b0, z);
    send_item(load_item(0, 32'h0001_0000), 1'b0, z);
    send_item(point_item(32'h0100_0000, '0, '0), 1'b0, z);
    send_item(point_item(32'hFF00_0000, '0, '0), 1'b0, z);
    send_item(load_item(11, 32'h0000_0001), 1'b0, z);
    send_item(point_item(32'h7FFF_FFFF, '0, '0), 1'b0, z);
    random_phase(150);
    drain();

    write_reg(REG_MIN_DEPTH, 31'h7FFF_FFFF);
    write_reg(REG_WINDOW_WIDTH, 31'(1));
    write_reg(REG_WINDOW_HEIGHT, 31'(16384));
    write_reg(REG_WINDOW_LEFT, 31'h0000_8000);
    write_reg(REG_WINDOW_TOP, 31'h0000_7FFF);
    write_reg(3'd7, 31'h1234);    // unused register index
    random_phase(100);
    drain();

    // Random settings in each round; the receiver stops stalling in one round, and each round drains.
    stall_en = 1'b0;
    for (k = 0; k < 5; k++) begin
      write_reg(REG_MIN_DEPTH, 31'($urandom_range(0, 32'h0002_0000)));
      write_reg(REG_WINDOW_WIDTH, 31'($urandom_range(1, 16384)));
      write_reg(REG_WINDOW_HEIGHT, 31'($urandom_range(1, 16384)));
      write_reg(REG_WINDOW_LEFT, 31'($urandom));
      write_reg(REG_WINDOW_TOP, 31'($urandom));
      stall_en = (k != 2);
      random_phase(220);
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
rtl/wsp_pkg.sv
rtl/wsp_clip.sv
rtl/wsp_div.sv
rtl/wsp_view.sv
rtl/world_to_screen_projection.sv
sim/world_to_screen_projection_tb.sv
